### src/ldr_pkg.sv
package ldr_pkg;

  localparam int ADC_BITS_DEFAULT = 12;
  localparam int SAMPLE_W         = 12;
  localparam int FS_W             = 16;
  localparam int VOLTS_W          = 18;
  localparam int BRIGHT_W         = 17;
  localparam int RES_W            = 36;
  localparam int LUX_W            = 32;
  localparam int RFIX_W           = 17;
  localparam int SCALE_W          = 32;
  localparam int GAMMA_W          = 16;
  localparam int CFG_DATA_W       = 32;
  localparam int CFG_IDX_W        = 2;
  localparam int FRAC_BITS        = 24;
  localparam int INT_W            = 6;
  localparam int LOG_W            = INT_W + FRAC_BITS;
  localparam int DIV_NUM_W        = 38;
  localparam int MAG_W            = 30;
  localparam int GDIV_NUM_W       = MAG_W + 12;
  localparam int P_W              = 31;

  localparam logic [RFIX_W-1:0] RFIX_RESET = RFIX_W'(10000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RFIX  = 2'd0,
    REG_EN    = 2'd1,
    REG_SCALE = 2'd2,
    REG_GAMMA = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [VOLTS_W-1:0]  volts;
    logic [BRIGHT_W-1:0] bright;
    logic [RES_W-1:0]    res;
    logic                lux_ok;
  } item_t;

  typedef struct packed {
    logic  neg;
    item_t item;
  } gdiv_side_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] b;
    x   = v;
    res = '0;
    b   = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (b > x) b = b >> 2;
    end
    for (int j = 0; j < 32; j++) begin
      if (b != 64'd0) begin
        if (x >= res + b) begin
          x   = x - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
    end
    return res;
  endfunction

  function automatic logic [31:0] exp_root(input int i);
    logic [63:0] root;
    root = 64'd2 << 30;
    for (int j = 1; j <= FRAC_BITS; j++) begin
      if (j <= i) root = isqrt64(root << 30);
    end
    return root[31:0];
  endfunction

endpackage

### src/ldr_div.sv
module ldr_div
  import ldr_pkg::*;
#(
  parameter int NW = 38,
  parameter int DW = 16,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [NW-1:0] quo,
  output logic [SW-1:0] side_out
);

  logic          vl  [NW+1];
  logic [DW-1:0] rem [NW+1];
  logic [NW-1:0] nm  [NW+1];
  logic [NW-1:0] qt  [NW+1];
  logic [DW-1:0] dn  [NW+1];
  logic [SW-1:0] sd  [NW+1];

  assign vl[0]  = in_valid;
  assign rem[0] = '0;
  assign nm[0]  = num;
  assign qt[0]  = '0;
  assign dn[0]  = den;
  assign sd[0]  = side_in;

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [DW:0] trial;
    logic        ge;
    logic [DW:0] diff;

    always_comb begin
      trial = {rem[i], nm[i][NW-1]};
      ge    = trial >= {1'b0, dn[i]};
      diff  = trial - {1'b0, dn[i]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[i+1] <= 1'b0;
      end else begin
        vl[i+1] <= vl[i];
      end
    end

    always_ff @(posedge clk) begin
      rem[i+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
      nm[i+1]  <= {nm[i][NW-2:0], 1'b0};
      qt[i+1]  <= {qt[i][NW-2:0], ge};
      dn[i+1]  <= dn[i];
      sd[i+1]  <= sd[i];
    end
  end

  assign out_valid = vl[NW];
  assign quo       = qt[NW];
  assign side_out  = sd[NW];

endmodule

### src/ldr_log2.sv
module ldr_log2
  import ldr_pkg::*;
#(
  parameter int SW = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [RES_W-1:0] x,
  input  logic [SW-1:0]    side_in,
  output logic             out_valid,
  output logic [LOG_W-1:0] lg,
  output logic [SW-1:0]    side_out
);

  logic             v0;
  logic [INT_W-1:0] n0;
  logic [RES_W-1:0] x0;
  logic [SW-1:0]    s0;
  logic [INT_W-1:0] n_next;

  always_comb begin
    n_next = '0;
    for (int b = 0; b < RES_W; b++) begin
      if (x[b]) n_next = INT_W'(b);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    n0 <= n_next;
    x0 <= x;
    s0 <= side_in;
  end

  logic                 vl [FRAC_BITS+1];
  logic [31:0]          mm [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] fr [FRAC_BITS+1];
  logic [INT_W-1:0]     nn [FRAC_BITS+1];
  logic [SW-1:0]        sd [FRAC_BITS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vl[0] <= 1'b0;
    end else begin
      vl[0] <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (n0 >= INT_W'(31)) begin
      mm[0] <= 32'(x0 >> (n0 - INT_W'(31)));
    end else begin
      mm[0] <= 32'(x0 << (INT_W'(31) - n0));
    end
    fr[0] <= '0;
    nn[0] <= n0;
    sd[0] <= s0;
  end

  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_sq
    logic [63:0] sq;
    logic [32:0] t;

    always_comb begin
      sq = 64'(mm[i]) * 64'(mm[i]);
      t  = sq[63:31];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[i+1] <= 1'b0;
      end else begin
        vl[i+1] <= vl[i];
      end
    end

    always_ff @(posedge clk) begin
      mm[i+1] <= t[32] ? t[32:1] : t[31:0];
      fr[i+1] <= {fr[i][FRAC_BITS-2:0], t[32]};
      nn[i+1] <= nn[i];
      sd[i+1] <= sd[i];
    end
  end

  assign out_valid = vl[FRAC_BITS];
  assign lg        = {nn[FRAC_BITS], fr[FRAC_BITS]};
  assign side_out  = sd[FRAC_BITS];

endmodule

### src/ldr_exp2.sv
module ldr_exp2
  import ldr_pkg::*;
#(
  parameter int SW = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 sat,
  input  logic                 under,
  input  logic [INT_W-1:0]     k,
  input  logic [FRAC_BITS-1:0] f,
  input  logic [SW-1:0]        side_in,
  output logic                 out_valid,
  output logic [LUX_W-1:0]     lux,
  output logic [SW-1:0]        side_out
);

  logic                 vl [FRAC_BITS+1];
  logic [P_W-1:0]       pp [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] ff [FRAC_BITS+1];
  logic [INT_W-1:0]     kk [FRAC_BITS+1];
  logic                 st [FRAC_BITS+1];
  logic                 un [FRAC_BITS+1];
  logic [SW-1:0]        sd [FRAC_BITS+1];

  assign vl[0] = in_valid;
  assign pp[0] = P_W'(64'd1 << 30);
  assign ff[0] = f;
  assign kk[0] = k;
  assign st[0] = sat;
  assign un[0] = under;
  assign sd[0] = side_in;

  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_mul
    localparam logic [31:0] ROOT = exp_root(i + 1);
    logic [63:0] prod;

    always_comb begin
      prod = 64'(pp[i]) * 64'(ROOT);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[i+1] <= 1'b0;
      end else begin
        vl[i+1] <= vl[i];
      end
    end

    always_ff @(posedge clk) begin
      pp[i+1] <= ff[i][FRAC_BITS-1-i] ? P_W'(prod >> 30) : pp[i];
      ff[i+1] <= ff[i];
      kk[i+1] <= kk[i];
      st[i+1] <= st[i];
      un[i+1] <= un[i];
      sd[i+1] <= sd[i];
    end
  end

  logic [6:0]  sh;
  logic [63:0] rnd;
  logic [63:0] r;
  logic [LUX_W-1:0] lux_next;

  always_comb begin
    sh  = 7'd32 - 7'(kk[FRAC_BITS]);
    rnd = '0;
    if (kk[FRAC_BITS] < INT_W'(32)) begin
      rnd = 64'(pp[FRAC_BITS]) + (64'd1 << (sh - 7'd1));
      r   = rnd >> sh;
    end else begin
      r   = 64'(pp[FRAC_BITS]) << (kk[FRAC_BITS] - INT_W'(32));
    end
    priority if (st[FRAC_BITS]) begin
      lux_next = '1;
    end else if (un[FRAC_BITS]) begin
      lux_next = '0;
    end else if (r > 64'(32'hFFFF_FFFF)) begin
      lux_next = '1;
    end else begin
      lux_next = r[LUX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vl[FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    lux      <= lux_next;
    side_out <= sd[FRAC_BITS];
  end

endmodule

### src/ldr_adc_to_lux.sv
// Channel   Handshake            Payload
// input     start / busy         adc_sample
// config    cfg_write            cfg_index, cfg_data
// result    done (one cycle)     volts, brightness, resistance, lux, lux_valid
//
// One sample enters per cycle while busy is low. Most of the pipeline depth lies in
// the bit-per-stage dividers (38 and 42 stages), the 24 squaring
// stages of the log unit and the 24 root-product stages of the exp unit.
// Reset clears all valid bits and loads register defaults; busy is high in reset.
// The result side cannot stall; every stage advances each cycle.
module ldr_adc_to_lux
  import ldr_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [SAMPLE_W-1:0]   adc_sample,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  done,
  output logic [VOLTS_W-1:0]    volts,
  output logic [BRIGHT_W-1:0]   brightness,
  output logic [RES_W-1:0]      resistance,
  output logic [LUX_W-1:0]      lux,
  output logic                  lux_valid
);

  localparam logic [FS_W-1:0] FS         = FS_W'((64'd1 << ADC_BITS) - 64'd1);
  localparam logic [31:0]     FS_HI      = 32'(64'(FS) * 64'd32999);

  // volts and brightness by reciprocal multiplication
  localparam int          NB_V   = 34;
  localparam int          NB_B   = 28;
  localparam logic [63:0] DEN_V  = 64'(FS) * 64'd10;
  localparam int          SH_V   = NB_V + $clog2(DEN_V);
  localparam logic [63:0] MUL_V  = ((64'd1 << SH_V) + DEN_V - 64'd1) / DEN_V;
  localparam logic [63:0] CM_V   = 64'(FS) * 64'd5 * MUL_V;
  localparam logic [63:0] DEN_B  = 64'(FS);
  localparam int          SH_B   = NB_B + $clog2(DEN_B);
  localparam logic [63:0] MUL_B  = ((64'd1 << SH_B) + DEN_B - 64'd1) / DEN_B;
  localparam logic [63:0] HM_B   = 64'(FS >> 1) * MUL_B;
  localparam int          VB_DLY = DIV_NUM_W - 4;

  logic [RFIX_W-1:0]  rfix;
  logic               cal_en;
  logic [SCALE_W-1:0] cal_scale;
  logic [GAMMA_W-1:0] cal_gamma;

  always_ff @(posedge clk) begin
    if (rst) begin
      rfix      <= RFIX_RESET;
      cal_en    <= 1'b0;
      cal_scale <= '0;
      cal_gamma <= '0;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_RFIX:  rfix      <= cfg_data[RFIX_W-1:0];
        REG_EN:    cal_en    <= cfg_data[0];
        REG_SCALE: cal_scale <= cfg_data[SCALE_W-1:0];
        REG_GAMMA: cal_gamma <= cfg_data[GAMMA_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  // sample stage
  logic                s0_valid;
  logic [SAMPLE_W-1:0] s0_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s0_s <= (FS_W'(adc_sample) > FS) ? SAMPLE_W'(FS) : adc_sample;
  end

  // clamp decision and products
  logic                s1_valid;
  logic [SAMPLE_W-1:0] s1_s;
  logic                s1_lo;
  logic                s1_hi;
  logic [32:0]         s1_prod_rfs;
  logic [32:0]         s1_prod_rlo;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_s        <= s0_s;
    s1_lo       <= (28'(s0_s) * 28'd33000) < 28'(FS);
    s1_hi       <= (32'(s0_s) * 32'd33000) > FS_HI;
    s1_prod_rfs <= 33'(rfix) * 33'(FS - FS_W'(s0_s));
    s1_prod_rlo <= 33'(rfix) * 33'd32999;
  end

  logic [DIV_NUM_W-1:0] res_num;
  logic [15:0]          res_den;

  always_comb begin
    priority if (s1_lo) begin
      res_num = DIV_NUM_W'({s1_prod_rlo, 4'b0000});
      res_den = 16'd1;
    end else if (s1_hi) begin
      res_num = DIV_NUM_W'({rfix, 4'b0000}) + DIV_NUM_W'(16499);
      res_den = 16'd32999;
    end else begin
      res_num = DIV_NUM_W'({s1_prod_rfs, 4'b0000}) + DIV_NUM_W'(s1_s >> 1);
      res_den = 16'(s1_s);
    end
  end

  logic                 rdiv_valid;
  logic [DIV_NUM_W-1:0] res_q;

  ldr_div #(.NW(DIV_NUM_W), .DW(16), .SW(1)) u_res_div (
    .clk, .rst,
    .in_valid (s1_valid),
    .num      (res_num),
    .den      (res_den),
    .side_in  (1'b0),
    .out_valid(rdiv_valid),
    .quo      (res_q),
    .side_out ()
  );

  // volts and brightness, aligned with the resistance quotient
  logic [17:0]                 vb_a;
  logic [SAMPLE_W-1:0]         vb_s;
  logic [35:0]                 vb_pl;
  logic [35:0]                 vb_ph;
  logic [41:0]                 vb_pb;
  logic [55:0]                 vb_x;
  logic [59:0]                 vb_tb;
  logic [71:0]                 vb_tv;
  logic [VOLTS_W-1:0]          vb_volts;
  logic [BRIGHT_W-1:0]         vb_bright;
  logic [VOLTS_W+BRIGHT_W-1:0] vb_dly [VB_DLY];

  assign vb_tv = (72'(vb_x) << 16) + 72'(CM_V);

  always_ff @(posedge clk) begin
    vb_a      <= 18'(s1_s) * 18'd33;
    vb_s      <= s1_s;
    vb_pl     <= 36'(vb_a) * 36'(MUL_V[17:0]);
    vb_ph     <= 36'(vb_a) * 36'(MUL_V[35:18]);
    vb_pb     <= 42'(vb_s) * 42'(MUL_B[29:0]);
    vb_x      <= (56'(vb_ph) << 18) + 56'(vb_pl);
    vb_tb     <= (60'(vb_pb) << 16) + 60'(HM_B);
    vb_volts  <= VOLTS_W'(vb_tv >> SH_V);
    vb_bright <= BRIGHT_W'(vb_tb >> SH_B);
    vb_dly[0] <= {vb_volts, vb_bright};
    for (int j = 1; j < VB_DLY; j++) begin
      vb_dly[j] <= vb_dly[j-1];
    end
  end

  // saturate resistance, qualify lux
  logic       s3_valid;
  item_t      s3_item;
  item_t      s3_item_next;

  always_comb begin
    s3_item_next.volts  = vb_dly[VB_DLY-1][VOLTS_W+BRIGHT_W-1:BRIGHT_W];
    s3_item_next.bright = vb_dly[VB_DLY-1][BRIGHT_W-1:0];
    s3_item_next.res    = (|res_q[DIV_NUM_W-1:RES_W]) ? '1 : res_q[RES_W-1:0];
    s3_item_next.lux_ok = cal_en && (cal_scale != '0) && (cal_gamma != '0) &&
                          (s3_item_next.res != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= rdiv_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_item <= s3_item_next;
  end

  logic             log_valid;
  logic [LOG_W-1:0] lg_res;
  logic [LOG_W-1:0] lg_scale;
  item_t            log_item;

  ldr_log2 #(.SW($bits(item_t))) u_log_res (
    .clk, .rst,
    .in_valid (s3_valid),
    .x        (s3_item.res),
    .side_in  (s3_item),
    .out_valid(log_valid),
    .lg       (lg_res),
    .side_out (log_item)
  );

  ldr_log2 #(.SW(1)) u_log_scale (
    .clk, .rst,
    .in_valid (s3_valid),
    .x        (RES_W'(cal_scale)),
    .side_in  (1'b0),
    .out_valid(),
    .lg       (lg_scale),
    .side_out ()
  );

  // log ratio, sign and magnitude
  logic              s4_valid;
  logic [MAG_W-1:0]  s4_mag;
  gdiv_side_t        s4_side;
  logic signed [31:0] l_diff;

  always_comb begin
    l_diff = $signed({2'b00, lg_scale}) - $signed({2'b00, lg_res}) - 32'sd67108864;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= log_valid;
    end
  end

  always_ff @(posedge clk) begin
    s4_side.neg  <= l_diff[31];
    s4_side.item <= log_item;
    s4_mag       <= l_diff[31] ? MAG_W'(-l_diff) : MAG_W'(l_diff);
  end

  logic                  gdiv_valid;
  logic [GDIV_NUM_W-1:0] gq;
  gdiv_side_t            gdiv_side;

  ldr_div #(.NW(GDIV_NUM_W), .DW(GAMMA_W), .SW($bits(gdiv_side_t))) u_gamma_div (
    .clk, .rst,
    .in_valid (s4_valid),
    .num      ({s4_mag, 12'd0}),
    .den      (cal_gamma),
    .side_in  (s4_side),
    .out_valid(gdiv_valid),
    .quo      (gq),
    .side_out (gdiv_side)
  );

  // exponent split
  logic                 s5_valid;
  logic                 s5_sat;
  logic                 s5_under;
  logic [INT_W-1:0]     s5_k;
  logic [FRAC_BITS-1:0] s5_f;
  item_t                s5_item;
  logic signed [43:0]   zq;
  logic signed [43:0]   u;

  always_comb begin
    zq = gdiv_side.neg ? -$signed({2'b00, gq}) : $signed({2'b00, gq});
    u  = zq + 44'sd167772160;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else begin
      s5_valid <= gdiv_valid;
    end
  end

  always_ff @(posedge clk) begin
    s5_sat   <= gdiv_side.item.lux_ok && (u >= 44'sd570425344);
    s5_under <= !gdiv_side.item.lux_ok || u[43];
    s5_k     <= u[FRAC_BITS+INT_W-1:FRAC_BITS];
    s5_f     <= u[FRAC_BITS-1:0];
    s5_item  <= gdiv_side.item;
  end

  item_t out_item;

  ldr_exp2 #(.SW($bits(item_t))) u_exp (
    .clk, .rst,
    .in_valid (s5_valid),
    .sat      (s5_sat),
    .under    (s5_under),
    .k        (s5_k),
    .f        (s5_f),
    .side_in  (s5_item),
    .out_valid(done),
    .lux      (lux),
    .side_out (out_item)
  );

  assign volts      = out_item.volts;
  assign brightness = out_item.bright;
  assign resistance = out_item.res;
  assign lux_valid  = out_item.lux_ok;

`ifndef SYNTHESIS
  a_no_done_after_rst: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");
  a_lux_zero: assert property (@(posedge clk) disable iff (rst)
    done && !lux_valid |-> lux == '0)
    else $error("lux nonzero without lux_valid");
  a_bright_max: assert property (@(posedge clk) disable iff (rst)
    done |-> brightness <= BRIGHT_W'(65536))
    else $error("brightness above full scale");
  a_res_nonzero: assert property (@(posedge clk) disable iff (rst)
    done && lux_valid |-> resistance != '0)
    else $error("lux_valid with zero resistance");
`endif

endmodule
